@@ rtl/core/psfr_pkg.sv @@
// Shared types and constants for the per-sender fragment reassembly block.
// Holds the stream field layout, opcode and result codes, and queue entry types.
// No dependencies.
package psfr_pkg;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 32;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic {
        OP_FRAG = 1'b0,
        OP_READ = 1'b1
    } t_opcode;

    typedef enum logic {
        KIND_DONE = 1'b0,
        KIND_READ = 1'b1
    } t_kind;

    // One classified item as it waits between the front and the back end.
    typedef struct packed {
        t_opcode     opcode;
        logic        sender_ok;
        logic [3:0]  sender;
        logic        is_final;
        logic        is_full;
        logic        idx_zero;
        logic [7:0]  frag_count;
        logic [15:0] proc_id;
        logic [31:0] message_id;
        logic [10:0] frag_payload_len;
        logic [13:0] byte_offset;
        logic [7:0]  payload_byte;
        logic        frag_end;
        logic        has_data;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  done_sender;
        logic [14:0] message_length;
        logic [7:0]  read_byte;
        logic        overflow;
    } t_result;

endpackage

@@ rtl/core/psfr_front.sv @@
// Front end: unpacks the input stream and classifies each fragment item.
// Classification depends only on the item itself, never on sender state.
// Depends on psfr_pkg.
module psfr_front import psfr_pkg::*; #(
    parameter int SENDERS            = 16,
    parameter int FRAG_PAYLOAD_BYTES = 1024
) (
    input  logic                  i_tvalid,
    output logic                  o_tready,
    input  logic [IN_TDATA_W-1:0] i_tdata,
    input  logic                  i_tuser,
    input  logic                  i_tlast,
    input  logic                  i_q_ready,
    output logic                  o_push,
    output t_item                 o_item
);

    logic [7:0]  w_idx;
    logic [7:0]  w_cnt;
    logic [10:0] w_plen;
    logic [13:0] w_off;
    logic        w_final;

    assign w_idx  = i_tdata[11:4];
    assign w_cnt  = i_tdata[19:12];
    assign w_plen = i_tdata[78:68];
    assign w_off  = i_tdata[92:79];

    // The final test compares index plus one against the count without wrap.
    assign w_final = ({1'b0, w_idx} + 9'd1) == {1'b0, w_cnt};

    assign o_tready = i_q_ready;
    assign o_push   = i_tvalid && i_q_ready;

    always_comb begin
        o_item                  = '0;
        o_item.opcode           = t_opcode'(i_tuser);
        o_item.sender           = i_tdata[3:0];
        o_item.sender_ok        = 32'(i_tdata[3:0]) < SENDERS;
        o_item.is_final         = w_final;
        o_item.is_full          = !w_final && (32'(w_plen) == FRAG_PAYLOAD_BYTES);
        o_item.idx_zero         = w_idx == 8'd0;
        o_item.frag_count       = w_cnt;
        o_item.proc_id          = i_tdata[35:20];
        o_item.message_id       = i_tdata[67:36];
        o_item.frag_payload_len = w_plen;
        o_item.byte_offset      = w_off;
        o_item.payload_byte     = i_tdata[100:93];
        o_item.frag_end         = i_tlast;
        o_item.has_data         = w_off < {3'b000, w_plen};
    end

endmodule

@@ rtl/core/psfr_queue.sv @@
// Short queue of classified items between the front and the back end.
// Lets the front keep accepting while the back end waits on the output.
// Depends on psfr_pkg.
module psfr_queue import psfr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_item        r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_cnt;
    logic [PW:0]   n_cnt;

    assign o_ready = r_cnt != (PW+1)'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_slot[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_item;
        end
    end

endmodule

@@ rtl/core/psfr_back.sv @@
// Back end: per-sender table, message buffer and result register.
// Executes one queued item per cycle unless it must wait for the output.
// Depends on psfr_pkg.
module psfr_back import psfr_pkg::*; #(
    parameter int SENDERS            = 16,
    parameter int FRAG_PAYLOAD_BYTES = 1024,
    parameter int MSG_BUFFER_BYTES   = 16384
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    localparam int SW   = (SENDERS > 1) ? $clog2(SENDERS) : 1;
    localparam int LW   = $clog2(MSG_BUFFER_BYTES + 1);
    localparam int AWB  = $clog2(MSG_BUFFER_BYTES);
    localparam int SUMW = ((LW > 14) ? LW : 14) + 1;
    localparam logic [LW-1:0] OPEN_LEN = LW'((FRAG_PAYLOAD_BYTES > MSG_BUFFER_BYTES) ?
                                             MSG_BUFFER_BYTES : FRAG_PAYLOAD_BYTES);
    localparam logic OPEN_OVF = FRAG_PAYLOAD_BYTES > MSG_BUFFER_BYTES;
    localparam logic [SUMW-1:0] BUF_LIMIT = SUMW'(MSG_BUFFER_BYTES);
    localparam logic [SUMW-1:0] FRAG_LEN  = SUMW'(FRAG_PAYLOAD_BYTES);
    localparam logic [LW-1:0]   LEN_MAX   = LW'(MSG_BUFFER_BYTES);

    // Sender table.
    logic [7:0]    r_rem [SENDERS];
    logic [15:0]   r_pid [SENDERS];
    logic [31:0]   r_mid [SENDERS];
    logic [LW-1:0] r_len [SENDERS];
    logic          r_ovf [SENDERS];

    // Message buffer, one region per sender.
    logic [7:0] r_mem [SENDERS][MSG_BUFFER_BYTES];
    logic [7:0] r_rd_data;

    // Result register.
    logic        r_out_valid;
    t_kind       r_out_kind;
    logic [3:0]  r_out_sender;
    logic [14:0] r_out_len;
    logic        r_out_ovf;
    logic        r_out_byte_ok;

    logic [SW-1:0]   w_s;
    logic [7:0]      w_rem;
    logic [LW-1:0]   w_len;
    logic            w_ovf;
    logic            w_match;
    logic            w_frag;
    logic            w_rd;
    logic            w_open;
    logic            w_extend;
    logic [SUMW-1:0] w_base;
    logic [SUMW-1:0] w_waddr;
    logic            w_we;
    logic            w_rd_in_buf;
    logic [7:0]      w_rem_dec;
    logic [SUMW-1:0] w_total_final;
    logic [SUMW-1:0] w_total_ext;
    logic [LW-1:0]   w_final_len;
    logic [LW-1:0]   w_ext_len;
    logic            w_done;
    logic            w_has_res;
    logic            w_go;

    assign w_s     = SW'(i_item.sender);
    assign w_rem   = r_rem[w_s];
    assign w_len   = r_len[w_s];
    assign w_ovf   = r_ovf[w_s];
    assign w_match = (i_item.proc_id == r_pid[w_s]) && (i_item.message_id == r_mid[w_s]);

    assign w_frag   = (i_item.opcode == OP_FRAG) && i_item.sender_ok;
    assign w_rd     = i_item.opcode == OP_READ;
    assign w_open   = i_item.is_full && i_item.idx_zero;
    assign w_extend = i_item.is_full && !i_item.idx_zero && w_match;

    // An opening fragment writes from the start of the region, others append.
    assign w_base  = w_open ? '0 : SUMW'(w_len);
    assign w_waddr = w_base + SUMW'(i_item.byte_offset);
    assign w_we    = w_frag && i_item.has_data && (w_waddr < BUF_LIMIT) &&
                     ((i_item.is_final && (w_rem == 8'd1)) || w_open || w_extend);

    assign w_rd_in_buf   = SUMW'(i_item.byte_offset) < BUF_LIMIT;
    assign w_rem_dec     = w_rem - 8'd1;
    assign w_total_final = SUMW'(w_len) + SUMW'(i_item.frag_payload_len);
    assign w_total_ext   = SUMW'(w_len) + FRAG_LEN;
    assign w_final_len   = (w_total_final > BUF_LIMIT) ? LEN_MAX : LW'(w_total_final);
    assign w_ext_len     = (w_total_ext > BUF_LIMIT) ? LEN_MAX : LW'(w_total_ext);

    assign w_done    = w_frag && i_item.is_final && i_item.frag_end && (w_rem_dec == 8'd0);
    assign w_has_res = w_rd || w_done;
    assign w_go      = i_valid && (!w_has_res || !r_out_valid || i_ready);
    assign o_pop     = w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SENDERS; i++) begin
                r_rem[i] <= '0;
                r_pid[i] <= '0;
                r_mid[i] <= '0;
                r_len[i] <= '0;
                r_ovf[i] <= 1'b0;
            end
        end else if (w_go && w_frag && i_item.frag_end) begin
            if (i_item.is_final) begin
                r_rem[w_s] <= w_rem_dec;
            end else if (w_open) begin
                r_pid[w_s] <= i_item.proc_id;
                r_mid[w_s] <= i_item.message_id;
                r_rem[w_s] <= i_item.frag_count - 8'd1;
                r_len[w_s] <= OPEN_LEN;
                r_ovf[w_s] <= OPEN_OVF;
            end else if (w_extend) begin
                r_rem[w_s] <= w_rem_dec;
                r_len[w_s] <= w_ext_len;
                if (w_total_ext > BUF_LIMIT) begin
                    r_ovf[w_s] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_we) begin
            r_mem[w_s][AWB'(w_waddr)] <= i_item.payload_byte;
        end
        if (w_go && w_rd && i_item.sender_ok && w_rd_in_buf) begin
            r_rd_data <= r_mem[w_s][AWB'(i_item.byte_offset)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && w_has_res) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_has_res) begin
            r_out_sender <= i_item.sender;
            if (w_rd) begin
                r_out_kind    <= KIND_READ;
                r_out_len     <= i_item.sender_ok ? 15'(w_len) : 15'd0;
                r_out_ovf     <= i_item.sender_ok && w_ovf;
                r_out_byte_ok <= i_item.sender_ok && w_rd_in_buf;
            end else begin
                r_out_kind    <= KIND_DONE;
                r_out_len     <= 15'(w_final_len);
                r_out_ovf     <= w_ovf || (w_total_final > BUF_LIMIT);
                r_out_byte_ok <= 1'b0;
            end
        end
    end

    assign o_valid                 = r_out_valid;
    assign o_result.kind           = r_out_kind;
    assign o_result.done_sender    = r_out_sender;
    assign o_result.message_length = r_out_len;
    assign o_result.read_byte      = r_out_byte_ok ? r_rd_data : 8'd0;
    assign o_result.overflow       = r_out_ovf;

endmodule

@@ rtl/core/per_sender_fragment_reassembly.sv @@
// Per-sender fragment reassembly: one payload byte or one buffer read per item.
// Each item passes through the queue, then the back end, which registers its result.
// Throughput: one item per cycle; the single buffer port and the result register
// set it, and a four-entry queue absorbs output stalls before input ready drops.
// Reset (synchronous, active low) clears the sender table, queue and result
// register; the message buffer is not cleared.
module per_sender_fragment_reassembly import psfr_pkg::*; #(
    parameter int SENDERS            = 16,
    parameter int FRAG_PAYLOAD_BYTES = 1024,
    parameter int MSG_BUFFER_BYTES   = 16384
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // sender[3:0], frag_index[11:4], frag_count[19:12], proc_id[35:20],
    // message_id[67:36], frag_payload_len[78:68], byte_offset[92:79],
    // payload_byte[100:93], zero fill[103:101]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode[0]
    input  logic                   s_axis_tuser,
    // frag_end
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // done_sender[3:0], message_length[18:4], read_byte[26:19], overflow[27],
    // zero fill[31:28]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // kind[0]
    output logic                   m_axis_tuser
);

    t_item   w_front_item;
    logic    w_push;
    logic    w_q_ready;
    logic    w_q_valid;
    t_item   w_q_item;
    logic    w_pop;
    t_result w_result;

    psfr_front #(
        .SENDERS            (SENDERS),
        .FRAG_PAYLOAD_BYTES (FRAG_PAYLOAD_BYTES)
    ) u_front (
        .i_tvalid  (s_axis_tvalid),
        .o_tready  (s_axis_tready),
        .i_tdata   (s_axis_tdata),
        .i_tuser   (s_axis_tuser),
        .i_tlast   (s_axis_tlast),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_item    (w_front_item)
    );

    psfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    psfr_back #(
        .SENDERS            (SENDERS),
        .FRAG_PAYLOAD_BYTES (FRAG_PAYLOAD_BYTES),
        .MSG_BUFFER_BYTES   (MSG_BUFFER_BYTES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_item   (w_q_item),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result)
    );

    assign m_axis_tdata = {4'b0000, w_result.overflow, w_result.read_byte,
                           w_result.message_length, w_result.done_sender};
    assign m_axis_tuser = w_result.kind;

endmodule

@@ rtl/core/psfr_check.sv @@
// Port-level checks for the per-sender fragment reassembly block.
// Bound to the top level; depends on psfr_pkg.
module psfr_check import psfr_pkg::*; #(
    parameter int SENDERS = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tuser
);

    // A stalled result must hold until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Reset leaves no result pending and an empty queue.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not idle after reset");

    // Completion results carry no read byte.
    a_done_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_DONE) |-> m_axis_tdata[26:19] == 8'd0)
        else $error("completion result with read byte");

    // A read for a sender outside the table answers with zero length, read byte and overflow.
    a_bad_sender_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_READ) &&
            (32'(m_axis_tdata[3:0]) >= SENDERS) |-> m_axis_tdata[27:4] == 24'd0)
        else $error("read of unknown sender returned data");

endmodule

bind per_sender_fragment_reassembly psfr_check #(.SENDERS(SENDERS)) u_psfr_check (.*);
